// File: rtl/feature_similarity_exp_grad_defines.svh
// ----------------------------------------------------------------------------
// Feature similarity assertion macros
// Shared assertion forms for the feature similarity block.
// ----------------------------------------------------------------------------
`ifndef FEATURE_SIMILARITY_EXP_GRAD_DEFINES_SVH
`define FEATURE_SIMILARITY_EXP_GRAD_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSEXG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsexg check failed");

// Consequent must hold in the cycle after the antecedent.
`define FSEXG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsexg check failed");

`endif

// File: rtl/fsexg_pkg.sv
// ----------------------------------------------------------------------------
// Feature similarity package
// Request and response types, operation and status codes, and the
// fixed-point constants of the exponential approximation.
// ----------------------------------------------------------------------------
package fsexg_pkg;

   localparam logic [1:0] OP_FWD  = 2'd0;
   localparam logic [1:0] OP_BWD  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ZERO_SCALE = 2'd1;
   localparam logic [1:0] ST_SAT        = 2'd2;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 31;

   localparam logic signed [39:0] LOG2E_Q16 = 40'sd94548;
   localparam logic signed [39:0] EXP_BIAS  = 40'sd137438953472;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] first_feature;
      logic signed [15:0] second_feature;
      logic signed [15:0] channel_scale;
      logic signed [15:0] upstream_grad;
      logic [7:0]         channel_index;
   } req_type;

   typedef struct packed {
      logic [31:0]        similarity;
      logic signed [31:0] grad_first;
      logic signed [31:0] grad_second;
      logic signed [47:0] scale_grad;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   function automatic logic [31:0] exp_coef(input logic [2:0] k);
      logic [31:0] c;
      unique case (k)
         3'd0:    c = 32'd1073741824;
         3'd1:    c = 32'd744261118;
         3'd2:    c = 32'd257941248;
         3'd3:    c = 32'd59597083;
         3'd4:    c = 32'd10327388;
         3'd5:    c = 32'd1431680;
         3'd6:    c = 32'd165394;
         default: c = 32'd0;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/fsexg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module fsexg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fsexg_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsexg_div (
   input  logic                    clock,
   input  logic                    reset,
   input  fsexg_pkg::div_req_type  div_req,
   output fsexg_pkg::div_rsp_type  div_rsp
);
   import fsexg_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [5:0]           cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W:0]   trial_w;
   logic                 fits_w;
   logic [DIV_DEN_W:0]   diff_w;

   assign trial_w = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits_w  = trial_w >= {1'b0, den_ff};
   assign diff_w  = trial_w - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
            rem_ff  <= '0;
            den_ff  <= div_req.den;
            quo_ff  <= div_req.num;
         end else if (busy_ff) begin
            rem_ff <= fits_w ? diff_w[DIV_DEN_W-1:0] : trial_w[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits_w};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// File: rtl/feature_similarity_exp_grad.sv
// Request to response: zero scale and the unused code skip the arithmetic, read
// and clear goes through the memory; the next request is taken once back in idle.
// One request at a time; the shared divider sets the pace (one pass forward,
// three backward), plus a multiplier used three times backward.
// Reset: synchronous; afterwards the block sweeps the accumulator memory to
// zero channel by channel and accepts no request during the sweep.
// ----------------------------------------------------------------------------
// Feature similarity with exponential kernel
// Computes the similarity, its gradients and per-channel scale gradients.
// ----------------------------------------------------------------------------
`include "feature_similarity_exp_grad_defines.svh"

module feature_similarity_exp_grad #(
   parameter int MAX_CHANNELS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fsexg_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fsexg_pkg::rsp_type rsp_data
);
   import fsexg_pkg::*;

   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PREP, S_DIV, S_EXPW, S_HORN, S_EXPS, S_MUL, S_READ, S_ACC,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_X, PH_Q, PH_E, PH_GRAD, PH_TERM1, PH_TERM2
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [AW-1:0]      clr_idx_ff;
   logic [1:0]         op_ff;
   logic signed [15:0] a_ff, b_ff, p_ff, g_ff;
   logic [7:0]         ch_ff;
   logic [31:0]        d2_ff;
   logic [30:0]        gdabs_ff;
   logic [30:0]        p2_ff;
   logic [15:0]        pabs_ff;
   logic [15:0]        gabs_ff;
   logic               pneg_ff, qneg_ff, gpos_ff;
   logic signed [21:0] x16_ff;
   logic [5:0]         n_ff;
   logic [15:0]        t_ff;
   logic [31:0]        m_ff;
   logic [2:0]         k_ff;
   logic [31:0]        y_ff;
   logic [63:0]        mul_a_ff;
   logic [31:0]        mul_b_ff;
   logic [95:0]        mul_acc_ff;
   logic [1:0]         mul_cnt_ff;
   logic [46:0]        tm_ff;
   div_req_type        div_req_ff;
   div_rsp_type        div_rsp;
   logic [31:0]        res_sim_ff;
   logic signed [31:0] res_grad_ff;
   logic signed [47:0] res_sg_ff;
   logic [1:0]         res_status_ff;
   logic               sat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic signed [16:0] d_w;
   logic signed [33:0] d_sq_w;
   logic signed [32:0] gd_w;
   logic signed [32:0] gd_abs_w;
   logic signed [31:0] p_sq_w;
   logic signed [16:0] p_abs_w;
   logic signed [16:0] g_abs_w;
   logic               ch_ok_w;
   logic [AW-1:0]      ch_addr_w;
   logic [20:0]        xlim_w;
   logic [20:0]        xmag_w;
   logic signed [21:0] x16_w;
   logic signed [39:0] wsum_w;
   logic [47:0]        horn_w;
   logic [34:0]        big_w;
   logic [31:0]        shr_w;
   logic               y_sat_w;
   logic [31:0]        y_w;
   logic [47:0]        pp_w;
   logic [95:0]        macc_w;
   logic               gsat_w;
   logic [30:0]        gmag_w;
   logic signed [31:0] grad_w;
   logic               tsat_w;
   logic signed [48:0] term_w;
   logic signed [48:0] sum_w;
   logic               acc_ovf_w;
   logic [47:0]        acc_new_w;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [47:0]        mem_wr_data;
   logic               mem_rd_en;
   logic [47:0]        mem_rd_data;

   assign d_w      = 17'(a_ff) - 17'(b_ff);
   assign d_sq_w   = 34'(d_w) * 34'(d_w);
   assign gd_w     = 33'(g_ff) * 33'(d_w);
   assign gd_abs_w = gd_w[32] ? -gd_w : gd_w;
   assign p_sq_w   = 32'(p_ff) * 32'(p_ff);
   assign p_abs_w  = p_ff[15] ? -17'(p_ff) : 17'(p_ff);
   assign g_abs_w  = g_ff[15] ? -17'(g_ff) : 17'(g_ff);
   assign ch_ok_w  = 32'(ch_ff) < 32'(MAX_CHANNELS);
   assign ch_addr_w = AW'(ch_ff);

   assign xlim_w = pneg_ff ? 21'd1048576 : 21'd786432;
   assign xmag_w = (div_rsp.quo > 48'(xlim_w)) ? xlim_w : div_rsp.quo[20:0];
   assign x16_w  = pneg_ff ? -$signed({1'b0, xmag_w}) : $signed({1'b0, xmag_w});
   assign wsum_w = 40'(x16_ff) * LOG2E_Q16 + EXP_BIAS;
   assign horn_w = 48'(m_ff) * 48'(t_ff);

   assign big_w   = 35'(m_ff) << (n_ff - 6'd46);
   assign shr_w   = m_ff >> (6'd46 - n_ff);
   assign y_sat_w = (n_ff >= 6'd46) && (big_w[34:32] != 3'd0);
   assign y_w     = (n_ff >= 6'd46) ? (y_sat_w ? 32'hFFFF_FFFF : big_w[31:0]) : shr_w;

   assign pp_w   = 48'(mul_a_ff[63:48]) * 48'(mul_b_ff);
   assign macc_w = {mul_acc_ff[79:0], 16'd0} + 96'(pp_w);
   assign gsat_w = macc_w[95:55] != '0;
   assign gmag_w = gsat_w ? '1 : macc_w[54:24];
   assign grad_w = qneg_ff ? -$signed({1'b0, gmag_w}) : $signed({1'b0, gmag_w});
   assign tsat_w = macc_w[95:63] != '0;

   assign term_w    = gpos_ff ? -$signed({2'b00, tm_ff}) : $signed({2'b00, tm_ff});
   assign sum_w     = 49'($signed(mem_rd_data)) + term_w;
   assign acc_ovf_w = sum_w[48] != sum_w[47];
   assign acc_new_w = acc_ovf_w ? (sum_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                                : sum_w[47:0];

   assign mem_rd_en   = (state_ff == S_PREP);
   assign mem_wr_en   = (state_ff == S_CLEAR) ||
                        (((state_ff == S_READ) || (state_ff == S_ACC)) && ch_ok_w);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_idx_ff : ch_addr_w;
   assign mem_wr_data = (state_ff == S_ACC) ? acc_new_w : 48'd0;

   fsexg_ram #(
      .WIDTH (48),
      .DEPTH (MAX_CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ch_addr_w),
      .rd_data (mem_rd_data)
   );

   fsexg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_idx_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + AW'(1);
               if (clr_idx_ff == AW'(MAX_CHANNELS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_data.operation;
                  a_ff     <= req_data.first_feature;
                  b_ff     <= req_data.second_feature;
                  p_ff     <= req_data.channel_scale;
                  g_ff     <= req_data.upstream_grad;
                  ch_ff    <= req_data.channel_index;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               d2_ff         <= d_sq_w[31:0];
               gdabs_ff      <= gd_abs_w[30:0];
               p2_ff         <= p_sq_w[30:0];
               pabs_ff       <= p_abs_w[15:0];
               gabs_ff       <= g_abs_w[15:0];
               pneg_ff       <= p_ff[15];
               qneg_ff       <= gd_w[32] ^ p_ff[15];
               gpos_ff       <= !g_ff[15] && (g_ff != 16'sd0);
               res_sim_ff    <= '0;
               res_grad_ff   <= '0;
               res_sg_ff     <= '0;
               res_status_ff <= ST_OK;
               sat_ff        <= 1'b0;
               if (op_ff == OP_NONE) begin
                  state_ff <= S_DONE;
               end else if (op_ff == OP_READ) begin
                  state_ff <= S_READ;
               end else if (p_ff == 16'sd0) begin
                  res_status_ff <= ST_ZERO_SCALE;
                  state_ff      <= S_DONE;
               end else begin
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= 48'(d_sq_w[31:0]) << 4;
                  div_req_ff.den   <= 31'(p_abs_w[15:0]);
                  phase_ff         <= PH_X;
                  state_ff         <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  unique case (phase_ff)
                     PH_X: begin
                        x16_ff   <= x16_w;
                        state_ff <= S_EXPW;
                     end
                     PH_Q: begin
                        mul_a_ff   <= 64'(div_rsp.quo);
                        mul_b_ff   <= y_ff;
                        mul_acc_ff <= '0;
                        mul_cnt_ff <= 2'd0;
                        phase_ff   <= PH_GRAD;
                        state_ff   <= S_MUL;
                     end
                     default: begin
                        mul_a_ff   <= 64'(div_rsp.quo);
                        mul_b_ff   <= 32'(gabs_ff);
                        mul_acc_ff <= '0;
                        mul_cnt_ff <= 2'd0;
                        phase_ff   <= PH_TERM1;
                        state_ff   <= S_MUL;
                     end
                  endcase
               end
            end
            S_EXPW: begin
               n_ff     <= wsum_w[37:32];
               t_ff     <= wsum_w[31:16];
               m_ff     <= exp_coef(3'd6);
               k_ff     <= 3'd5;
               state_ff <= S_HORN;
            end
            S_HORN: begin
               m_ff <= exp_coef(k_ff) + horn_w[47:16];
               k_ff <= k_ff - 3'd1;
               if (k_ff == 3'd0) begin
                  state_ff <= S_EXPS;
               end
            end
            S_EXPS: begin
               y_ff       <= y_w;
               res_sim_ff <= y_w;
               sat_ff     <= y_sat_w;
               if (op_ff == OP_FWD) begin
                  state_ff <= S_DONE;
               end else begin
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= 48'(gdabs_ff) << 13;
                  div_req_ff.den   <= 31'(pabs_ff);
                  phase_ff         <= PH_Q;
                  state_ff         <= S_DIV;
               end
            end
            S_MUL: begin
               mul_acc_ff <= macc_w;
               mul_a_ff   <= mul_a_ff << 16;
               mul_cnt_ff <= mul_cnt_ff + 2'd1;
               if (mul_cnt_ff == 2'd3) begin
                  priority case (phase_ff)
                     PH_GRAD: begin
                        res_grad_ff      <= grad_w;
                        sat_ff           <= sat_ff | gsat_w;
                        div_req_ff.start <= 1'b1;
                        div_req_ff.num   <= 48'(d2_ff) << 16;
                        div_req_ff.den   <= p2_ff;
                        phase_ff         <= PH_E;
                        state_ff         <= S_DIV;
                     end
                     PH_TERM1: begin
                        mul_a_ff   <= 64'(macc_w[62:12]);
                        mul_b_ff   <= y_ff;
                        mul_acc_ff <= '0;
                        mul_cnt_ff <= 2'd0;
                        phase_ff   <= PH_TERM2;
                     end
                     default: begin
                        tm_ff    <= tsat_w ? '1 : macc_w[62:16];
                        sat_ff   <= sat_ff | tsat_w;
                        state_ff <= S_ACC;
                     end
                  endcase
               end
            end
            S_READ: begin
               if (ch_ok_w) begin
                  res_sg_ff <= $signed(mem_rd_data);
               end
               state_ff <= S_DONE;
            end
            S_ACC: begin
               if (ch_ok_w && acc_ovf_w) begin
                  sat_ff <= 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.similarity  <= res_sim_ff;
                  rsp_data_ff.grad_first  <= res_grad_ff;
                  rsp_data_ff.grad_second <= -res_grad_ff;
                  rsp_data_ff.scale_grad  <= res_sg_ff;
                  rsp_data_ff.status      <= sat_ff ? ST_SAT : res_status_ff;
                  state_ff                <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FSEXG_ASSERT_SAME(a_clear_blocks, clock, reset, state_ff == S_CLEAR, !req_ready)
   `FSEXG_ASSERT_SAME(a_grad_pair, clock, reset, rsp_valid, rsp_data.grad_second == -rsp_data.grad_first)
   `FSEXG_ASSERT_SAME(a_div_owner, clock, reset, div_rsp.done, state_ff == S_DIV)
   `FSEXG_ASSERT_NEXT(a_zero_scale, clock, reset, state_ff == S_PREP && (op_ff == OP_FWD || op_ff == OP_BWD) && p_ff == 16'sd0, state_ff == S_DONE && res_status_ff == ST_ZERO_SCALE)

endmodule
